// ===== rtl/core/vrt_pkg.sv =====
// Shared types, constants and register map of the raster timing register file.
package vrt_pkg;

    localparam int LINE_WIDTH      = 504;
    localparam int LINES_PER_FRAME = 312;
    localparam int DISPLAY_START_X = 48;
    localparam int DISPLAY_START_Y = 51;
    localparam int COLOR_RAM_DEPTH = 1024;

    localparam int CRAM_AW    = $clog2(COLOR_RAM_DEPTH);
    localparam int SPRITES    = 8;
    localparam int MISC_COUNT = 5;
    localparam int PAL_COUNT  = 15;

    localparam logic [5:0] CRAM_PAGE = 6'h36;

    localparam logic [9:0] COL_STEP    = 10'd8;
    localparam logic [9:0] COL_DSX     = 10'(DISPLAY_START_X);
    localparam logic [9:0] COL_LIMIT   = 10'(LINE_WIDTH);
    localparam logic [9:0] HEND_WIDE   = 10'(DISPLAY_START_X + 320);
    localparam logic [9:0] HEND_NARROW = 10'(DISPLAY_START_X + 304);
    localparam logic [8:0] LINE_LIMIT  = 9'(LINES_PER_FRAME);
    localparam logic [8:0] LINE_DSY    = 9'(DISPLAY_START_Y);
    localparam logic [8:0] VEND_TALL   = 9'(DISPLAY_START_Y + 200);
    localparam logic [8:0] VEND_SHORT  = 9'(DISPLAY_START_Y + 192);

    localparam logic [5:0] REG_SPR_LAST = 6'h0F;
    localparam logic [5:0] REG_XHIGH    = 6'h10;
    localparam logic [5:0] REG_CTRL1    = 6'h11;
    localparam logic [5:0] REG_RASTER   = 6'h12;
    localparam logic [5:0] REG_SPR_EN   = 6'h15;
    localparam logic [5:0] REG_CTRL2    = 6'h16;
    localparam logic [5:0] REG_YEXP     = 6'h17;
    localparam logic [5:0] REG_MEMPTR   = 6'h18;
    localparam logic [5:0] REG_IRQ_STAT = 6'h19;
    localparam logic [5:0] REG_IRQ_EN   = 6'h1A;
    localparam logic [5:0] REG_PRIO     = 6'h1B;
    localparam logic [5:0] REG_MCOLOR   = 6'h1C;
    localparam logic [5:0] REG_XEXP     = 6'h1D;
    localparam logic [5:0] REG_COLL_SS  = 6'h1E;
    localparam logic [5:0] REG_COLL_SB  = 6'h1F;
    localparam logic [5:0] REG_PAL_FIRST = 6'h20;
    localparam logic [5:0] REG_PAL_LAST  = 6'h2E;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       irq_pending;
        logic [8:0] raster_line;
        logic [9:0] raster_column;
        logic [1:0] border_flags;
        logic       frame_start;
    } result_t;

    typedef struct packed {
        logic               access;
        logic               write;
        logic [CRAM_AW-1:0] index;
        logic [7:0]         wdata;
    } cram_req_t;

endpackage

// ===== rtl/core/video_raster_timing_register_file.sv =====
// Top level: input stage, color RAM, register file and result register.
//
//  channel | ports                                             | direction
//  s_      | s_valid s_ready s_opcode s_address s_write_data   | in
//  m_      | m_valid m_ready m_read_data m_irq_request         | out
//          | m_irq_pending m_raster_line m_raster_column       |
//          | m_border_flags m_frame_start                      |
//
// One beat per cycle unless stalled; a beat goes through the input stage, then out_reg.
// The color RAM is read or written at accept; its registered read feeds the result.
// After reset s_ready stays low while the color RAM is zeroed.
// A stalled m_ side holds the result; the input stage still fills behind it.
module video_raster_timing_register_file
    import vrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_irq_request,
    output logic        m_irq_pending,
    output logic [8:0]  m_raster_line,
    output logic [9:0]  m_raster_column,
    output logic [1:0]  m_border_flags,
    output logic        m_frame_start
);

    logic       st_valid_reg;
    item_t      st_item_reg;
    logic       m_valid_reg;
    result_t    out_reg;
    logic       advance, accept, cram_ready;
    logic [7:0] cram_rdata;
    cram_req_t  cram_req;
    result_t    result;

    assign advance = st_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = cram_ready && (!st_valid_reg || advance);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cram_req.access = accept && s_address[15:10] == CRAM_PAGE;
        cram_req.write  = op_t'(s_opcode) == OP_WRITE;
        cram_req.index  = s_address[CRAM_AW-1:0];
        cram_req.wdata  = s_write_data;
    end

    vrt_color_ram u_cram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cram_req),
        .rdata   (cram_rdata),
        .ready   (cram_ready)
    );

    vrt_regfile u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (st_item_reg),
        .cram_rdata (cram_rdata),
        .retire     (advance),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_item_reg.op         <= op_t'(s_opcode);
            st_item_reg.address    <= s_address;
            st_item_reg.write_data <= s_write_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = out_reg.read_data;
    assign m_irq_request   = out_reg.irq_request;
    assign m_irq_pending   = out_reg.irq_pending;
    assign m_raster_line   = out_reg.raster_line;
    assign m_raster_column = out_reg.raster_column;
    assign m_border_flags  = out_reg.border_flags;
    assign m_frame_start   = out_reg.frame_start;

endmodule

// ===== rtl/core/vrt_color_ram.sv =====
// Color RAM with registered read and a zeroing sweep after reset.
module vrt_color_ram
    import vrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cram_req_t  req,
    output logic [7:0] rdata,
    output logic       ready
);

    logic [7:0]       mem [COLOR_RAM_DEPTH];
    logic [7:0]       rdata_reg;
    logic [CRAM_AW:0] clr_cnt_reg;
    logic             clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (CRAM_AW + 1)'(COLOR_RAM_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg[CRAM_AW-1:0]] <= 8'h00;
        end else if (req.access) begin
            if (req.write) begin
                mem[req.index] <= req.wdata;
            end
            rdata_reg <= mem[req.index];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

// ===== rtl/core/vrt_regfile.sv =====
// Register file and raster counters: next state and result of one beat.
module vrt_regfile
    import vrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  item_t      item,
    input  logic [7:0] cram_rdata,
    input  logic       retire,
    output result_t    result
);

    logic [7:0]  xlo_reg [SPRITES];
    logic [7:0]  ypos_reg [SPRITES];
    logic [7:0]  misc_reg [MISC_COUNT];
    logic [7:0]  pal_reg [PAL_COUNT];
    logic [7:0]  xhigh_reg, ctrl1_reg, ctrl2_reg, memptr_reg, irq_stat_reg, irq_en_reg;
    logic [8:0]  compare_reg, line_reg;
    logic [9:0]  column_reg;
    logic [1:0]  border_reg;
    logic [15:0] frame_cnt_reg;

    logic [7:0]  xhigh_next, ctrl1_next, ctrl2_next, memptr_next, irq_stat_next, irq_en_next;
    logic [8:0]  compare_next, line_next;
    logic [9:0]  column_next;
    logic [1:0]  border_next;
    logic [15:0] frame_cnt_next;

    logic [5:0]  sel;
    logic        is_cram, is_sprite, is_pal, is_misc;
    logic [2:0]  misc_idx;
    logic [7:0]  rd, stat_clr;
    logic [9:0]  col, hend;
    logic [8:0]  ln_inc, ln, vend;
    logic        irq_req, frame_pulse;

    always_comb begin
        sel       = item.address[5:0];
        is_cram   = item.address[15:10] == CRAM_PAGE;
        is_sprite = sel <= REG_SPR_LAST;
        is_pal    = sel >= REG_PAL_FIRST && sel <= REG_PAL_LAST;
        is_misc   = 1'b1;
        case (sel)
            REG_SPR_EN: misc_idx = 3'd0;
            REG_YEXP:   misc_idx = 3'd1;
            REG_PRIO:   misc_idx = 3'd2;
            REG_MCOLOR: misc_idx = 3'd3;
            REG_XEXP:   misc_idx = 3'd4;
            default: begin
                misc_idx = 3'd0;
                is_misc  = 1'b0;
            end
        endcase

        if (is_cram) begin
            rd = cram_rdata;
        end else if (is_sprite) begin
            rd = sel[0] ? ypos_reg[sel[3:1]] : xlo_reg[sel[3:1]];
        end else if (is_pal) begin
            rd = pal_reg[sel[3:0]];
        end else if (is_misc) begin
            rd = misc_reg[misc_idx];
        end else begin
            case (sel)
                REG_XHIGH:    rd = xhigh_reg;
                REG_CTRL1:    rd = ctrl1_reg;
                REG_RASTER:   rd = line_reg[7:0];
                REG_CTRL2:    rd = ctrl2_reg;
                REG_MEMPTR:   rd = memptr_reg | 8'h01;
                REG_IRQ_STAT: rd = irq_stat_reg | 8'h70;
                REG_IRQ_EN:   rd = irq_en_reg | 8'hF0;
                REG_COLL_SS:  rd = 8'h00;
                REG_COLL_SB:  rd = 8'h00;
                default:      rd = 8'hFF;
            endcase
        end

        xhigh_next     = xhigh_reg;
        ctrl1_next     = ctrl1_reg;
        ctrl2_next     = ctrl2_reg;
        memptr_next    = memptr_reg;
        irq_stat_next  = irq_stat_reg;
        irq_en_next    = irq_en_reg;
        compare_next   = compare_reg;
        line_next      = line_reg;
        column_next    = column_reg;
        border_next    = border_reg;
        frame_cnt_next = frame_cnt_reg;
        irq_req        = 1'b0;
        frame_pulse    = 1'b0;

        stat_clr = irq_stat_reg & ~item.write_data;
        col      = column_reg + COL_STEP;
        hend     = ctrl2_reg[3] ? HEND_WIDE : HEND_NARROW;
        ln_inc   = line_reg + 9'd1;
        ln       = (ln_inc >= LINE_LIMIT) ? 9'd0 : ln_inc;
        vend     = ctrl1_reg[3] ? VEND_TALL : VEND_SHORT;

        case (item.op)
            OP_WRITE: begin
                if (!is_cram && !is_sprite && !is_pal && !is_misc) begin
                    case (sel)
                        REG_XHIGH: xhigh_next = item.write_data;
                        REG_CTRL1: begin
                            ctrl1_next   = {ctrl1_reg[7], item.write_data[6:0]};
                            compare_next = {item.write_data[7], compare_reg[7:0]};
                        end
                        REG_RASTER:   compare_next = {compare_reg[8], item.write_data};
                        REG_CTRL2:    ctrl2_next = item.write_data;
                        REG_MEMPTR:   memptr_next = item.write_data;
                        REG_IRQ_STAT: irq_stat_next = (stat_clr == 8'h80) ? 8'h00 : stat_clr;
                        REG_IRQ_EN:   irq_en_next = item.write_data;
                        default: ;
                    endcase
                end
            end
            OP_TICK: begin
                column_next = col;
                if (col == COL_DSX) begin
                    border_next[0] = 1'b0;
                end else if (col == hend) begin
                    border_next[0] = 1'b1;
                end
                if (col >= COL_LIMIT) begin
                    column_next = '0;
                    line_next   = ln;
                    if (ln == 9'd0) begin
                        frame_cnt_next = frame_cnt_reg + 16'd1;
                        frame_pulse    = 1'b1;
                    end
                    ctrl1_next = {ln[8], ctrl1_reg[6:0]};
                    if (ln == LINE_DSY) begin
                        border_next[1] = 1'b0;
                    end else if (ln == vend) begin
                        border_next[1] = 1'b1;
                    end
                    if (!irq_stat_reg[7] && irq_en_reg[0] && compare_reg == ln) begin
                        irq_stat_next = irq_stat_reg | 8'h81;
                        irq_req       = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        result.read_data     = (item.op == OP_READ) ? rd : 8'h00;
        result.irq_request   = irq_req;
        result.irq_pending   = irq_stat_next[7];
        result.raster_line   = line_next;
        result.raster_column = column_next;
        result.border_flags  = border_next;
        result.frame_start   = frame_pulse;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SPRITES; i++) begin
                xlo_reg[i]  <= '0;
                ypos_reg[i] <= '0;
            end
            for (int i = 0; i < MISC_COUNT; i++) begin
                misc_reg[i] <= '0;
            end
            for (int i = 0; i < PAL_COUNT; i++) begin
                pal_reg[i] <= '0;
            end
            xhigh_reg     <= '0;
            ctrl1_reg     <= '0;
            ctrl2_reg     <= '0;
            memptr_reg    <= '0;
            irq_stat_reg  <= '0;
            irq_en_reg    <= '0;
            compare_reg   <= '0;
            line_reg      <= '0;
            column_reg    <= '0;
            border_reg    <= '0;
            frame_cnt_reg <= '0;
        end else if (retire) begin
            if (item.op == OP_WRITE && !is_cram) begin
                if (is_sprite) begin
                    if (sel[0]) begin
                        ypos_reg[sel[3:1]] <= item.write_data;
                    end else begin
                        xlo_reg[sel[3:1]] <= item.write_data;
                    end
                end else if (is_pal) begin
                    pal_reg[sel[3:0]] <= item.write_data | 8'hF0;
                end else if (is_misc) begin
                    misc_reg[misc_idx] <= item.write_data;
                end
            end
            xhigh_reg     <= xhigh_next;
            ctrl1_reg     <= ctrl1_next;
            ctrl2_reg     <= ctrl2_next;
            memptr_reg    <= memptr_next;
            irq_stat_reg  <= irq_stat_next;
            irq_en_reg    <= irq_en_next;
            compare_reg   <= compare_next;
            line_reg      <= line_next;
            column_reg    <= column_next;
            border_reg    <= border_next;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

endmodule

// ===== bench/tb_video_raster_timing_register_file.sv =====
// Self-checking testbench: directed table, random mix, raster interrupt sweep.
module tb_video_raster_timing_register_file;
    timeunit 1ns;
    timeprecision 1ps;
    import vrt_pkg::*;

    localparam logic [5:0] REG_VOID_LO  = 6'h13;
    localparam logic [5:0] REG_VOID_PAL = 6'h2F;
    localparam logic [5:0] REG_VOID_HI  = 6'h3F;

    localparam int RANDOM_BEATS = 700;
    localparam int SWEEP_BEATS  = 160;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  reps;
        logic        pinned;
        logic [7:0]  rd;
    } script_row_t;

    localparam script_row_t SCRIPT [27] = '{
        '{OP_READ,  16'h0000,                 8'h00, 8'd1,  1'b1, 8'h00},
        '{OP_READ,  {10'h000, REG_IRQ_STAT},  8'h00, 8'd1,  1'b1, 8'h70},
        '{OP_READ,  {10'h000, REG_IRQ_EN},    8'h00, 8'd1,  1'b1, 8'hF0},
        '{OP_READ,  {10'h000, REG_MEMPTR},    8'h00, 8'd1,  1'b1, 8'h01},
        '{OP_READ,  {10'h000, REG_VOID_LO},   8'h00, 8'd1,  1'b1, 8'hFF},
        '{OP_READ,  16'hFFFF,                 8'hFF, 8'd1,  1'b1, 8'hFF},
        '{OP_WRITE, 16'hD800,                 8'hFF, 8'd1,  1'b0, 8'h00},
        '{OP_WRITE, 16'hDBFF,                 8'hA5, 8'd1,  1'b0, 8'h00},
        '{OP_READ,  16'hD800,                 8'h00, 8'd1,  1'b1, 8'hFF},
        '{OP_READ,  16'hDBFF,                 8'h00, 8'd1,  1'b1, 8'hA5},
        '{OP_READ,  16'hD7FF,                 8'h00, 8'd1,  1'b1, 8'hFF},
        '{OP_READ,  16'hDC00,                 8'h00, 8'd1,  1'b1, 8'h00},
        '{OP_WRITE, {10'h000, REG_PAL_FIRST}, 8'h00, 8'd1,  1'b0, 8'h00},
        '{OP_READ,  {10'h000, REG_PAL_FIRST}, 8'h00, 8'd1,  1'b1, 8'hF0},
        '{OP_WRITE, {10'h000, REG_COLL_SB},   8'hFF, 8'd1,  1'b0, 8'h00},
        '{OP_READ,  {10'h000, REG_COLL_SB},   8'h00, 8'd1,  1'b1, 8'h00},
        '{OP_WRITE, {10'h000, REG_XHIGH},     8'hFF, 8'd1,  1'b0, 8'h00},
        '{OP_READ,  16'h000E,                 8'h00, 8'd1,  1'b1, 8'h00},
        '{OP_WRITE, {10'h000, REG_IRQ_EN},    8'h01, 8'd1,  1'b0, 8'h00},
        '{OP_WRITE, {10'h000, REG_RASTER},    8'h01, 8'd1,  1'b0, 8'h00},
        '{OP_TICK,  16'hFFFF,                 8'hFF, 8'd63, 1'b0, 8'h00},
        '{OP_READ,  {10'h000, REG_IRQ_STAT},  8'h00, 8'd1,  1'b1, 8'hF1},
        '{OP_WRITE, {10'h000, REG_IRQ_STAT},  8'h01, 8'd1,  1'b0, 8'h00},
        '{OP_READ,  {10'h000, REG_IRQ_STAT},  8'h00, 8'd1,  1'b1, 8'h70},
        '{OP_NOP,   {10'h000, REG_IRQ_STAT},  8'hFF, 8'd1,  1'b1, 8'h00},
        '{OP_WRITE, {10'h000, REG_CTRL1},     8'h80, 8'd1,  1'b0, 8'h00},
        '{OP_READ,  {10'h000, REG_CTRL1},     8'h00, 8'd1,  1'b1, 8'h00}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [15:0] s_address;
    logic [7:0]  s_write_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_irq_request;
    logic        m_irq_pending;
    logic [8:0]  m_raster_line;
    logic [9:0]  m_raster_column;
    logic [1:0]  m_border_flags;
    logic        m_frame_start;

    video_raster_timing_register_file u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq_request   (m_irq_request),
        .m_irq_pending   (m_irq_pending),
        .m_raster_line   (m_raster_line),
        .m_raster_column (m_raster_column),
        .m_border_flags  (m_border_flags),
        .m_frame_start   (m_frame_start)
    );

    // predicted chip state
    logic [7:0] cram_copy [COLOR_RAM_DEPTH];
    logic [8:0] spr_x [SPRITES];
    logic [7:0] spr_y [SPRITES];
    logic [7:0] misc_q [MISC_COUNT];
    logic [7:0] pal_q [PAL_COUNT];
    logic [7:0] xhigh_q, ctrl1_q, ctrl2_q, memptr_q, irq_stat_q, irq_en_q;
    logic [8:0] cmp_q, line_q;
    logic [9:0] col_q;
    logic [1:0] border_q;

    result_t results_due [$];
    int      burst_left = 0;
    bit      hold_req = 1'b0;
    int      op_tally [4] = '{0, 0, 0, 0};
    int      frames_wrapped = 0;
    int      irq_raised = 0;
    int      beats_checked = 0;
    int      mismatch_count = 0;
    int      stray_count = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("video_raster_timing_register_file: mismatch");
        $finish;
    end

    function automatic int misc_slot(input logic [5:0] r);
        case (r)
            REG_SPR_EN: return 0;
            REG_YEXP:   return 1;
            REG_PRIO:   return 2;
            REG_MCOLOR: return 3;
            REG_XEXP:   return 4;
            default:    return -1;
        endcase
    endfunction

    function automatic logic [7:0] reg_fetch(input logic [15:0] a);
        logic [5:0] r;
        int m;
        r = a[5:0];
        m = misc_slot(r);
        if (a >= 16'hD800 && a < 16'hDC00) return cram_copy[a[9:0]];
        if (r <= REG_SPR_LAST) return r[0] ? spr_y[r[3:1]] : spr_x[r[3:1]][7:0];
        if (r >= REG_PAL_FIRST && r <= REG_PAL_LAST) return pal_q[r[3:0]];
        if (m >= 0) return misc_q[m];
        case (r)
            REG_XHIGH:                return xhigh_q;
            REG_CTRL1:                return ctrl1_q;
            REG_RASTER:               return line_q[7:0];
            REG_CTRL2:                return ctrl2_q;
            REG_MEMPTR:               return memptr_q | 8'h01;
            REG_IRQ_STAT:             return irq_stat_q | 8'h70;
            REG_IRQ_EN:               return irq_en_q | 8'hF0;
            REG_COLL_SS, REG_COLL_SB: return 8'h00;
            default:                  return 8'hFF;
        endcase
    endfunction

    function automatic void reg_store(input logic [15:0] a, input logic [7:0] d);
        logic [5:0] r;
        int m;
        r = a[5:0];
        m = misc_slot(r);
        if (a >= 16'hD800 && a < 16'hDC00) begin
            cram_copy[a[9:0]] = d;
        end else if (r <= REG_SPR_LAST) begin
            if (r[0]) spr_y[r[3:1]] = d;
            else spr_x[r[3:1]][7:0] = d;
        end else if (r >= REG_PAL_FIRST && r <= REG_PAL_LAST) begin
            pal_q[r[3:0]] = d | 8'hF0;
        end else if (m >= 0) begin
            misc_q[m] = d;
        end else begin
            case (r)
                REG_XHIGH: begin
                    xhigh_q = d;
                    for (int i = 0; i < SPRITES; i++) spr_x[i][8] = d[i];
                end
                REG_CTRL1: begin
                    ctrl1_q[6:0] = d[6:0];
                    cmp_q[8] = d[7];
                end
                REG_RASTER: cmp_q[7:0] = d;
                REG_CTRL2:  ctrl2_q = d;
                REG_MEMPTR: memptr_q = d;
                REG_IRQ_STAT: begin
                    irq_stat_q = irq_stat_q & ~d;
                    if (irq_stat_q == 8'h80) irq_stat_q = 8'h00;
                end
                REG_IRQ_EN: irq_en_q = d;
                default: ;
            endcase
        end
    endfunction

    function automatic void beam_advance(output logic irq_hit, output logic wrapped);
        logic [9:0] col, hend;
        logic [8:0] ln, vend;
        irq_hit = 1'b0;
        wrapped = 1'b0;
        col = col_q + 10'd8;
        hend = 10'(DISPLAY_START_X) + (ctrl2_q[3] ? 10'd320 : 10'd304);
        col_q = col;
        if (col == 10'(DISPLAY_START_X)) border_q[0] = 1'b0;
        else if (col == hend) border_q[0] = 1'b1;
        if (col >= 10'(LINE_WIDTH)) begin
            col_q = '0;
            ln = line_q + 9'd1;
            if (ln >= 9'(LINES_PER_FRAME)) ln = '0;
            line_q = ln;
            if (ln == '0) begin
                frames_wrapped++;
                wrapped = 1'b1;
            end
            ctrl1_q[7] = ln[8];
            vend = 9'(DISPLAY_START_Y) + (ctrl1_q[3] ? 9'd200 : 9'd192);
            if (ln == 9'(DISPLAY_START_Y)) border_q[1] = 1'b0;
            else if (ln == vend) border_q[1] = 1'b1;
            if (!irq_stat_q[7] && irq_en_q[0] && cmp_q == ln) begin
                irq_stat_q = irq_stat_q | 8'h81;
                irq_hit = 1'b1;
            end
        end
    endfunction

    function automatic result_t raster_predict(input op_t op, input logic [15:0] a,
                                               input logic [7:0] d);
        result_t res;
        logic irq_hit, wrapped;
        res = '0;
        irq_hit = 1'b0;
        wrapped = 1'b0;
        case (op)
            OP_READ:  res.read_data = reg_fetch(a);
            OP_WRITE: reg_store(a, d);
            OP_TICK:  beam_advance(irq_hit, wrapped);
            default: ;
        endcase
        res.irq_request   = irq_hit;
        res.irq_pending   = irq_stat_q[7];
        res.raster_line   = line_q;
        res.raster_column = col_q;
        res.border_flags  = border_q;
        res.frame_start   = wrapped;
        return res;
    endfunction

    function automatic logic [15:0] pick_address();
        logic [5:0] r;
        r = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 9))
            0, 1:    return 16'hD800 + 16'($urandom_range(0, 15));
            2:       return 16'hD800 + 16'($urandom_range(0, COLOR_RAM_DEPTH - 1));
            3:       return 16'($urandom);
            4, 5:    return {10'($urandom), r};
            default: return {10'h000, r};
        endcase
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_beat(input op_t op, input logic [15:0] a, input logic [7:0] d,
                             input bit pinned = 1'b0, input logic [7:0] pin_rd = 8'h00);
        result_t due;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_address    <= a;
        s_write_data <= d;
        do @(posedge aclk); while (!s_ready);
        due = raster_predict(op, a, d);
        if (pinned) due.read_data = pin_rd;
        if (due.irq_request) irq_raised++;
        results_due.push_back(due);
        op_tally[op]++;
    endtask

    task automatic random_beat(input bit allow_tick);
        int pick;
        pick = allow_tick ? $urandom_range(0, 99) : $urandom_range(40, 99);
        if (pick < 37) push_beat(OP_TICK, 16'($urandom), 8'($urandom));
        else if (pick < 40) push_beat(OP_NOP, 16'($urandom), 8'($urandom));
        else if (pick < 70) push_beat(OP_READ, pick_address(), pick_data());
        else push_beat(OP_WRITE, pick_address(), pick_data());
    endtask

    task automatic aim_compare(input logic [8:0] c);
        push_beat(OP_WRITE, {10'h000, REG_CTRL1}, {c[8], 7'($urandom)});
        push_beat(OP_WRITE, {10'h000, REG_RASTER}, c[7:0]);
    endtask

    // result side: check each beat, stall on a shifting pattern or at random, long hold on request
    initial begin : result_sink
        result_t got, want;
        int hold_left, phase_left, mode;
        logic [15:0] pattern;
        hold_left = 0;
        phase_left = 0;
        mode = 0;
        pattern = 16'h0001;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_read_data, m_irq_request, m_irq_pending, m_raster_line,
                       m_raster_column, m_border_flags, m_frame_start};
                if (results_due.size() == 0) begin
                    stray_count++;
                    if (mismatch_count + stray_count <= REPORT_LIMIT)
                        $display({"unexpected beat: rd=%02h irq=%b pend=%b",
                                  " line=%0d col=%0d bd=%b fs=%b"},
                                 got.read_data, got.irq_request, got.irq_pending,
                                 got.raster_line, got.raster_column, got.border_flags,
                                 got.frame_start);
                end else begin
                    want = results_due.pop_front();
                    beats_checked++;
                    if (got.read_data !== want.read_data || got.irq_request !== want.irq_request
                        || got.irq_pending !== want.irq_pending
                        || got.raster_line !== want.raster_line
                        || got.raster_column !== want.raster_column
                        || got.border_flags !== want.border_flags
                        || got.frame_start !== want.frame_start) begin
                        mismatch_count++;
                        if (mismatch_count + stray_count <= REPORT_LIMIT) begin
                            $display({"beat %0d expected rd=%02h irq=%b pend=%b",
                                      " line=%0d col=%0d bd=%b fs=%b"},
                                     beats_checked, want.read_data, want.irq_request,
                                     want.irq_pending, want.raster_line, want.raster_column,
                                     want.border_flags, want.frame_start);
                            $display({"beat %0d actual   rd=%02h irq=%b pend=%b",
                                      " line=%0d col=%0d bd=%b fs=%b"},
                                     beats_checked, got.read_data, got.irq_request,
                                     got.irq_pending, got.raster_line, got.raster_column,
                                     got.border_flags, got.frame_start);
                        end
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 200);
                pattern = 16'($urandom) | 16'h0001;
            end
            phase_left--;
            pattern = {pattern[14:0], pattern[15]};
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= pattern[0];
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [8:0] next_cmp;
        logic [7:0] ack;
        s_valid      <= 1'b0;
        s_opcode     <= OP_READ;
        s_address    <= '0;
        s_write_data <= '0;
        aresetn      <= 1'b0;
        foreach (cram_copy[i]) cram_copy[i] = '0;
        foreach (spr_x[i]) spr_x[i] = '0;
        foreach (spr_y[i]) spr_y[i] = '0;
        foreach (misc_q[i]) misc_q[i] = '0;
        foreach (pal_q[i]) pal_q[i] = '0;
        {xhigh_q, ctrl1_q, ctrl2_q, memptr_q, irq_stat_q, irq_en_q} = '0;
        {cmp_q, line_q, col_q, border_q} = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[i])
            repeat (SCRIPT[i].reps)
                push_beat(SCRIPT[i].op, SCRIPT[i].addr, SCRIPT[i].data,
                          SCRIPT[i].pinned, SCRIPT[i].rd);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 2) hold_req = 1'b1;
            random_beat(1'b1);
        end

        // tick through a few lines with the raster interrupt armed, acknowledging and re-aiming it
        push_beat(OP_WRITE, {10'h000, REG_IRQ_EN}, 8'($urandom) | 8'h01);
        aim_compare(line_q + 9'd1);
        for (int k = 0; k < SWEEP_BEATS; k++) begin
            if (irq_stat_q[7] && $urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       ack = 8'h01;
                    1:       ack = 8'h81;
                    2:       ack = 8'h80;
                    default: ack = 8'($urandom);
                endcase
                push_beat(OP_WRITE, {10'h000, REG_IRQ_STAT}, ack);
                case ($urandom_range(0, 3))
                    0:       next_cmp = 9'($urandom_range(256, LINES_PER_FRAME - 1));
                    1:       next_cmp = '0;
                    default: next_cmp = 9'((int'(line_q) + $urandom_range(1, 3))
                                           % LINES_PER_FRAME);
                endcase
                aim_compare(next_cmp);
                if ($urandom_range(0, 3) == 0)
                    push_beat(OP_WRITE, {10'h000, REG_CTRL2}, pick_data());
            end else if ($urandom_range(0, 29) == 0) begin
                random_beat(1'b0);
            end else begin
                push_beat(OP_TICK, 16'($urandom), 8'($urandom));
            end
        end
        s_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("%0d beats: %0d reads, %0d writes, %0d pixel ticks, %0d idle opcodes",
                 beats_checked, op_tally[OP_READ], op_tally[OP_WRITE], op_tally[OP_TICK],
                 op_tally[OP_NOP]);
        $display("beam reached line %0d after %0d frame wrap(s), raster interrupt raised %0d time(s)",
                 line_q, frames_wrapped, irq_raised);
        if (mismatch_count == 0 && stray_count == 0 && results_due.size() == 0)
            $display("video_raster_timing_register_file: match");
        else
            $display("video_raster_timing_register_file: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/vrt_pkg.sv
rtl/core/vrt_color_ram.sv
rtl/core/vrt_regfile.sv
rtl/core/video_raster_timing_register_file.sv
bench/tb_video_raster_timing_register_file.sv
